// File: rtl/biquad_pkg.sv
// Shared types and constants for the biquad IIR filter.
// Used by biquad_ctrl, biquad_datapath and biquad_iir_filter. No dependencies.
`timescale 1ns / 1ps

package biquad_pkg;

  // Default formats: Q1.23 samples and Q5.27 coefficients.
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;

  // The state holds eight fraction bits below the sample LSB.
  localparam int GUARD_FRAC = 8;

  // Coefficient register map.
  localparam int NUM_COEFS      = 5;
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_A2 = 3'd4;

  // Sequencer states, one per step of the shared multiplier.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_ACC0,
    ST_FORM_Y,
    ST_N2,
    ST_SUB1,
    ST_SUB2,
    ST_UPDATE
  } state_t;

  // Accumulator operations applied to the rounded product.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC0,
    OP_FORM_Y,
    OP_N2,
    OP_SUB1,
    OP_SUB2,
    OP_UPDATE
  } op_t;

  // Control from the sequencer to the datapath and output stage.
  typedef struct packed {
    logic                      load_in;
    logic [CFG_INDEX_BITS-1:0] coef_sel;
    logic                      mul_y;
    op_t                       op;
    logic                      out_load;
  } dp_ctrl_t;

endpackage

// File: rtl/biquad_ctrl.sv
// Sequencer for the biquad filter: steps one item through the shared multiplier.
// Depends on biquad_pkg.
`timescale 1ns / 1ps

module biquad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_free,
  output biquad_pkg::dp_ctrl_t ctrl
);
  import biquad_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL_B0;
      end
      ST_MUL_B0: state_next = ST_ACC0;
      ST_ACC0:   state_next = ST_FORM_Y;
      ST_FORM_Y: state_next = ST_N2;
      ST_N2:     state_next = ST_SUB1;
      ST_SUB1:   state_next = ST_SUB2;
      ST_SUB2:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Output decode: multiplier operands for the next product and the
  // accumulator operation on the product registered last cycle.
  always_comb begin
    in_ready      = 1'b0;
    ctrl.load_in  = 1'b0;
    ctrl.coef_sel = REG_B0;
    ctrl.mul_y    = 1'b0;
    ctrl.op       = OP_NONE;
    ctrl.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.load_in = in_valid;
      end
      ST_MUL_B0: begin
        ctrl.coef_sel = REG_B0;
      end
      ST_ACC0: begin
        ctrl.coef_sel = REG_B1;
        ctrl.op       = OP_ACC0;
      end
      ST_FORM_Y: begin
        ctrl.coef_sel = REG_B2;
        ctrl.op       = OP_FORM_Y;
      end
      ST_N2: begin
        ctrl.coef_sel = REG_A1;
        ctrl.mul_y    = 1'b1;
        ctrl.op       = OP_N2;
      end
      ST_SUB1: begin
        ctrl.coef_sel = REG_A2;
        ctrl.mul_y    = 1'b1;
        ctrl.op       = OP_SUB1;
      end
      ST_SUB2: begin
        ctrl.op = OP_SUB2;
      end
      ST_UPDATE: begin
        if (out_free) begin
          ctrl.op       = OP_UPDATE;
          ctrl.out_load = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/biquad_datapath.sv
// Biquad arithmetic: one shared signed multiplier, product rounding,
// accumulators, saturation and the two delay states.
// Depends on biquad_pkg.
`timescale 1ns / 1ps

module biquad_datapath #(
  parameter int SAMPLE_BITS = biquad_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biquad_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  biquad_pkg::dp_ctrl_t          ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [COEF_BITS-1:0]   coef [biquad_pkg::NUM_COEFS],
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output logic                          clip_out
);
  import biquad_pkg::*;

  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int PROD_SHIFT = COEF_BITS - 13;
  localparam int STATE_BITS = SAMPLE_BITS + 16;
  localparam int ACC_BITS   = STATE_BITS + 2;

  localparam logic [PROD_BITS:0] PROD_HALF =
    {{PROD_BITS{1'b0}}, 1'b1} << (PROD_SHIFT - 1);
  localparam logic [ACC_BITS-1:0] ACC_HALF =
    {{(ACC_BITS-1){1'b0}}, 1'b1} << (GUARD_FRAC - 1);
  localparam logic signed [ACC_BITS-1:0] SMP_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [ACC_BITS-1:0] ST_MAX =
    {{(ACC_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ST_MIN = ~ST_MAX;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    n1;
  logic signed [ACC_BITS-1:0]    n2;
  logic signed [STATE_BITS-1:0]  d1;
  logic signed [STATE_BITS-1:0]  d2;
  logic                          clip_q;

  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_BITS:0]     prod_half;
  logic signed [ACC_BITS-1:0]    prod_rnd;
  logic signed [ACC_BITS-1:0]    acc_half;
  logic signed [ACC_BITS-1:0]    y_full;
  logic                          y_hi;
  logic                          y_lo;
  logic                          n1_hi;
  logic                          n1_lo;
  logic                          n2_hi;
  logic                          n2_lo;

  // Multiplier operand selection.
  assign mul_a = coef[ctrl.coef_sel];
  assign mul_b = ctrl.mul_y ? y_q : x_q;

  // Round the registered product half up to the state format.
  assign prod_half = {prod[PROD_BITS-1], prod} + signed'(PROD_HALF);
  assign prod_rnd  = ACC_BITS'(prod_half >>> PROD_SHIFT);

  // Round the output accumulator to sample width and detect overflow.
  assign acc_half = acc + signed'(ACC_HALF);
  assign y_full   = acc_half >>> GUARD_FRAC;
  assign y_hi     = y_full > SMP_MAX;
  assign y_lo     = y_full < SMP_MIN;

  // Overflow of the new delay states.
  assign n1_hi = n1 > ST_MAX;
  assign n1_lo = n1 < ST_MIN;
  assign n2_hi = n2 > ST_MAX;
  assign n2_lo = n2 < ST_MIN;

  // Shared multiplier, registered every cycle.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Payload registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      x_q    <= sample_in;
      clip_q <= 1'b0;
    end
    case (ctrl.op)
      OP_ACC0: begin
        acc <= prod_rnd + ACC_BITS'(d1);
      end
      OP_FORM_Y: begin
        if (y_hi) begin
          y_q <= SMP_MAX[SAMPLE_BITS-1:0];
        end else if (y_lo) begin
          y_q <= SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
          y_q <= y_full[SAMPLE_BITS-1:0];
        end
        clip_q <= clip_q | y_hi | y_lo;
        n1     <= prod_rnd + ACC_BITS'(d2);
      end
      OP_N2: begin
        n2 <= prod_rnd;
      end
      OP_SUB1: begin
        n1 <= n1 - prod_rnd;
      end
      OP_SUB2: begin
        n2 <= n2 - prod_rnd;
      end
      default: begin
      end
    endcase
  end

  // Delay states, cleared at reset and saturated on update.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (ctrl.op == OP_UPDATE) begin
      if (n1_hi) begin
        d1 <= ST_MAX[STATE_BITS-1:0];
      end else if (n1_lo) begin
        d1 <= ST_MIN[STATE_BITS-1:0];
      end else begin
        d1 <= n1[STATE_BITS-1:0];
      end
      if (n2_hi) begin
        d2 <= ST_MAX[STATE_BITS-1:0];
      end else if (n2_lo) begin
        d2 <= ST_MIN[STATE_BITS-1:0];
      end else begin
        d2 <= n2[STATE_BITS-1:0];
      end
    end
  end

  // Result of the item, valid during the update step.
  assign y_out    = y_q;
  assign clip_out = clip_q | n1_hi | n1_lo | n2_hi | n2_lo;

endmodule

// File: rtl/biquad_iir_filter.sv
// Top level of the biquad IIR filter: stream ports, coefficient registers
// and output register. Depends on biquad_pkg, biquad_ctrl and biquad_datapath.
`timescale 1ns / 1ps

// Second-order IIR filter, direct form II transposed, in fixed point.
// Input stream (s_*): one signed sample per item in s_tdata, block end in
// s_tlast. Output stream (m_*): filtered, saturated sample in m_tdata,
// saturation flag in m_tuser, block end copied to m_tlast.
// Coefficients b0, b1, b2, a1, a2 are written on the cfg port at indexes
// 0 to 4; other indexes are ignored. cfg_ready is always high. Write
// them only while no item is in flight.
// Each item has one accept step and seven steps that share a
// single multiplier for the five products, then the output register loads.
// m_tvalid rises as that register loads; a new item is accepted only after
// the last one leaves its final step. A stalled receiver holds the result
// in the output register; the next item may still be taken and is held at
// its final step until that register frees.
// Synchronous reset clears both delay states, empties the output register,
// and restores b0 = 1.0 and the other coefficients to zero.
module biquad_iir_filter #(
  parameter int SAMPLE_BITS = biquad_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = biquad_pkg::COEF_BITS_DEF,
  localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input items.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [DATA_BITS-1:0]                  s_tdata,   // sample_in
  input  logic                                  s_tlast,   // block_end
  // Result items.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [DATA_BITS-1:0]                  m_tdata,   // sample_out
  output logic                                  m_tuser,   // clipped
  output logic                                  m_tlast,   // block_end_out
  // Coefficient writes.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [biquad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]                  cfg_data
);
  import biquad_pkg::*;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-1){1'b0}}, 1'b1} << (COEF_BITS - 5);

  logic signed [COEF_BITS-1:0]   coef [NUM_COEFS];
  logic                          last_q;
  logic [SAMPLE_BITS-1:0]        sample_out;
  logic                          clipped;
  logic                          block_end_out;
  logic                          out_free;
  dp_ctrl_t                      ctrl;
  logic signed [SAMPLE_BITS-1:0] y_res;
  logic                          clip_res;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= COEF_ONE;
      coef[1] <= '0;
      coef[2] <= '0;
      coef[3] <= '0;
      coef[4] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0:  coef[0] <= cfg_data;
        REG_B1:  coef[1] <= cfg_data;
        REG_B2:  coef[2] <= cfg_data;
        REG_A1:  coef[3] <= cfg_data;
        REG_A2:  coef[4] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  biquad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Arithmetic and delay states.
  biquad_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample_in (s_tdata[SAMPLE_BITS-1:0]),
    .coef      (coef),
    .y_out     (y_res),
    .clip_out  (clip_res)
  );

  // Block end marker rides along with the item.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      last_q <= s_tlast;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      sample_out    <= y_res;
      clipped       <= clip_res;
      block_end_out <= last_q;
    end
  end

  assign m_tdata = DATA_BITS'(sample_out);
  assign m_tuser = clipped;
  assign m_tlast = block_end_out;

endmodule

// File: tb/biquad_iir_filter_tb.sv
// Self-checking testbench for the biquad IIR filter: directed and random items
// checked against a fixed-point predictor. Depends on biquad_pkg and biquad_iir_filter.
`timescale 1ns / 1ps

module biquad_iir_filter_tb;
  import biquad_pkg::*;

  localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
  localparam int COEF_W          = COEF_BITS_DEF;
  localparam int DATA_W          = ((SAMPLE_W + 7) / 8) * 8;
  localparam int STATE_W         = SAMPLE_W + 16;
  localparam int PROD_SHIFT      = COEF_W - 13;
  localparam int CYCLES_PER_ITEM = 8;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int MAX_REPORTS     = 10;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_TOP = '1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_PAST = CFG_INDEX_BITS'(NUM_COEFS);
  localparam logic [COEF_W-1:0]         COEF_ONE      = 1 << (COEF_W - 5);
  localparam logic [COEF_W-1:0]         COEF_MAX      = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic [COEF_W-1:0]         COEF_MIN      = {1'b1, {(COEF_W - 1){1'b0}}};

  // One result item as it leaves the filter.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
    logic                last;
  } filter_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,   // coefficient write, done while the filter is idle
    ROW_SAMPLE,  // sample checked against the predictor
    ROW_TYPED    // sample with its result written out in the table
  } row_kind_t;

  typedef enum logic [1:0] {
    STYLE_TAME,
    STYLE_WILD,
    STYLE_EDGE
  } coef_style_t;

  // Directed stimulus row. The index is unused on sample rows.
  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COEF_W-1:0]         value;
    logic                      last;
    logic [SAMPLE_W-1:0]       exp_sample;
    logic                      exp_clip;
  } stim_row_t;

  localparam int N_DIRECTED = 32;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Unity gain after reset: samples pass through unchanged.
    '{ROW_TYPED,  REG_B0,        32'h007F_FFFF, 1'b0, 24'h7F_FFFF, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h0080_0000, 1'b1, 24'h80_0000, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h0000_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h0000_0001, 1'b0, 24'h00_0001, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h00FF_FFFF, 1'b1, 24'hFF_FFFF, 1'b0},
    // Largest positive gain drives the output into both rails.
    '{ROW_WRITE,  REG_B0,        COEF_MAX,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h007F_FFFF, 1'b0, 24'h7F_FFFF, 1'b1},
    '{ROW_TYPED,  REG_B0,        32'h0080_0000, 1'b1, 24'h80_0000, 1'b1},
    // Largest negative gain flips the rails.
    '{ROW_WRITE,  REG_B0,        COEF_MIN,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h007F_FFFF, 1'b0, 24'h80_0000, 1'b1},
    '{ROW_TYPED,  REG_B0,        32'h0080_0000, 1'b0, 24'h7F_FFFF, 1'b1},
    // Writes to indexes past the register map must leave b0 alone.
    '{ROW_WRITE,  CFG_INDEX_PAST, 32'h0000_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  CFG_INDEX_TOP, 32'h0000_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_TYPED,  REG_B0,        32'h0000_0001, 1'b0, 24'hFF_FFF0, 1'b0},
    // Smallest gain: products land exactly on half an LSB.
    '{ROW_WRITE,  REG_B0,        32'h0000_0001, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h0004_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h00FC_0000, 1'b1, 24'h00_0000, 1'b0},
    // Extreme feed-forward and feedback terms drive the output into saturation.
    '{ROW_WRITE,  REG_B0,        COEF_ONE,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_B1,        COEF_MAX,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_B2,        COEF_MIN,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_A1,        COEF_MIN,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_A2,        COEF_MAX,      1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h007F_FFFF, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h0080_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h007F_FFFF, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h0000_0000, 1'b1, 24'h00_0000, 1'b0},
    // A stable section with a double real pole at 0.75.
    '{ROW_WRITE,  REG_B1,        32'h1000_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_A1,        32'hF400_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_WRITE,  REG_A2,        32'h0480_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h0010_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h0000_0000, 1'b0, 24'h00_0000, 1'b0},
    '{ROW_SAMPLE, REG_B0,        32'h00F0_0000, 1'b1, 24'h00_0000, 1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [DATA_W-1:0]         s_tdata = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [DATA_W-1:0]         m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data = '0;

  // Predictor state: coefficients and the two delay registers.
  longint coef_q [NUM_COEFS];
  longint state_one;
  longint state_two;

  filter_result_t expected_q [$];
  int             mismatches = 0;
  int             cycle_count = 0;
  int             rx_hold = 0;
  logic           tx_calm = 1'b0;
  logic           rx_calm = 1'b0;

  biquad_iir_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Round half up: add half an LSB of the target, then shift with floor.
  function automatic longint round_off(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint coef_product(longint c, longint x);
    return round_off(c * x, PROD_SHIFT);
  endfunction

  // Advances the filter by one sample and returns the result it must produce.
  function automatic filter_result_t filter_sample(logic [SAMPLE_W-1:0] x_bits, logic last);
    filter_result_t res;
    longint x, acc, y_raw, y, n1, n2, s1, s2;
    x     = longint'($signed(x_bits));
    acc   = coef_product(coef_q[REG_B0], x) + state_one;
    y_raw = round_off(acc, GUARD_FRAC);
    y     = clamp(y_raw, SAMPLE_W);
    // The saturated output is what feeds back into both states.
    n1 = coef_product(coef_q[REG_B1], x) - coef_product(coef_q[REG_A1], y) + state_two;
    n2 = coef_product(coef_q[REG_B2], x) - coef_product(coef_q[REG_A2], y);
    s1 = clamp(n1, STATE_W);
    s2 = clamp(n2, STATE_W);
    state_one   = s1;
    state_two   = s2;
    res.sample  = y[SAMPLE_W-1:0];
    res.clipped = (y != y_raw) || (s1 != n1) || (s2 != n2);
    res.last    = last;
    return res;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int tx_gap();
    if (tx_calm || $urandom_range(0, 2) != 0) return 0;
    return pause_len();
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] x;
    int                  r;
    r = $urandom_range(0, 19);
    if (r < 12) x = SAMPLE_W'($urandom);
    else if (r < 15) x = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
    else if (r < 17) begin
      case ($urandom_range(0, 3))
        0:       x = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        1:       x = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        2:       x = '0;
        default: x = '1;
      endcase
    end else x = SAMPLE_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    return x;
  endfunction

  // Tame sets keep gains near unity and poles mostly inside the unit circle.
  function automatic logic [COEF_W-1:0] pick_coef(coef_style_t style, int idx);
    logic [COEF_W-1:0] c;
    int                span;
    span = (idx == REG_A1) ? (1 << 28) : (1 << 27);
    case (style)
      STYLE_TAME: c = COEF_W'(int'($urandom_range(0, 2 * span)) - span);
      STYLE_WILD: c = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       c = COEF_MAX;
          1:       c = COEF_MIN;
          2:       c = '0;
          3:       c = COEF_ONE;
          4:       c = -COEF_ONE;
          default: c = $urandom;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic write_coef(input logic [CFG_INDEX_BITS-1:0] idx,
                            input logic [COEF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_COEFS) coef_q[idx] = longint'($signed(value));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic last,
                             input logic use_typed, input filter_result_t typed,
                             input int gap);
    filter_result_t want;
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(x);
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = filter_sample(x, last);
    if (use_typed) want = typed;
    expected_q.push_back(want);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the input side until every outstanding result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (2 * CYCLES_PER_ITEM) @(posedge clk);
  endtask

  task automatic log_mismatch(input string what, input filter_result_t want,
                              input filter_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected sample %h clipped %b last %b,",
               what, want.sample, want.clipped, want.last,
               " got sample %h clipped %b last %b",
               got.sample, got.clipped, got.last);
    end
  endtask

  // Receiver side: random stalls, switched off during calm phases.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 4) == 0) rx_hold <= pause_len();
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    filter_result_t got;
    filter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.sample  = m_tdata[SAMPLE_W-1:0];
      got.clipped = m_tuser;
      got.last    = m_tlast;
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.sample !== want.sample) log_mismatch("sample", want, got);
        if (got.clipped !== want.clipped) log_mismatch("clipped flag", want, got);
        if (got.last !== want.last) log_mismatch("block end", want, got);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("biquad_iir_filter verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t      row;
    filter_result_t typed;
    coef_style_t    style;
    int             pause_at;

    // Predictor starts from the reset state: unity b0, everything else zero.
    for (int i = 0; i < NUM_COEFS; i++) coef_q[i] = 0;
    coef_q[REG_B0] = longint'(COEF_ONE);
    state_one = 0;
    state_two = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        write_coef(row.index, row.value);
      end else begin
        typed.sample  = row.exp_sample;
        typed.clipped = row.exp_clip;
        typed.last    = row.last;
        send_sample(row.value[SAMPLE_W-1:0], row.last, row.kind == ROW_TYPED, typed,
                    tx_gap());
      end
    end

    // Random phases, each with a fresh coefficient set.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      style = coef_style_t'(phase % 3);
      for (int r = 0; r < NUM_COEFS; r++) begin
        write_coef(r[CFG_INDEX_BITS-1:0], pick_coef(style, r));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_coef(CFG_INDEX_BITS'($urandom_range(NUM_COEFS, CFG_INDEX_TOP)), $urandom);
      end
      tx_calm  = (phase % 4 == 1);
      rx_calm  = (phase % 4 == 2);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ? ITEMS_PER_PHASE / 2 : -1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == pause_at) wait_drained();
        send_sample(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, '0, tx_gap());
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("biquad_iir_filter verification clean");
    end else begin
      $display("biquad_iir_filter verification failed");
    end
    $finish;
  end

endmodule
